@@ sv/pdg_pkg.sv @@
`default_nettype none

package pdg_pkg;

    localparam int FIX_W    = 32;
    localparam int TIME_W   = 17;
    localparam int COEF_W   = 31;
    localparam int LIFE_W   = 8;
    localparam int TT_W     = 18;
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int QUO_W    = 63;
    localparam int SQRT_LAT = ROOT_W;
    localparam int DIV_LAT  = QUO_W;
    localparam int HEAD_LAT = 3;
    localparam int TAIL_LAT = 5;
    localparam int PIPE_LAT = HEAD_LAT + SQRT_LAT + DIV_LAT + TAIL_LAT;
    localparam int CFG_IDX_W = 3;

    localparam logic [TIME_W-1:0] RST_TIME_STEP = TIME_W'(6554);
    localparam logic [COEF_W-1:0] RST_GRAVITY   = COEF_W'(642253);
    localparam logic [COEF_W-1:0] RST_DRAG_C    = COEF_W'(2621);
    localparam logic [COEF_W-1:0] RST_DRAG_L    = COEF_W'(328);
    localparam logic [COEF_W-1:0] RST_DRAG_Q    = COEF_W'(197);
    localparam logic signed [FIX_W-1:0] RST_LAT_GAIN = -32'sd65536;
    localparam logic signed [FIX_W-1:0] RST_FLOOR    = 32'sd655360;
    localparam logic [LIFE_W-1:0] RST_LIFE_FLOOR = LIFE_W'(10);
    localparam logic [TT_W-1:0] RST_TT = TT_W'((6554 * 6554) >> 16);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP,
        CFG_GRAVITY,
        CFG_DRAG_CONSTANT,
        CFG_DRAG_LINEAR,
        CFG_DRAG_QUADRATIC,
        CFG_LATERAL_GAIN,
        CFG_FLOOR_HEIGHT,
        CFG_LIFE_FLOOR
    } cfg_idx_t;

    typedef struct packed {
        logic signed [FIX_W-1:0] pos_x;
        logic signed [FIX_W-1:0] pos_y;
        logic signed [FIX_W-1:0] pos_z;
        logic signed [FIX_W-1:0] vel_x;
        logic signed [FIX_W-1:0] vel_y;
        logic signed [FIX_W-1:0] vel_z;
        logic [LIFE_W-1:0]       life_left;
        logic                    last_in_burst;
    } particle_t;

    typedef struct packed {
        logic signed [FIX_W-1:0] new_pos_x;
        logic signed [FIX_W-1:0] new_pos_y;
        logic signed [FIX_W-1:0] new_pos_z;
        logic signed [FIX_W-1:0] new_vel_x;
        logic signed [FIX_W-1:0] new_vel_y;
        logic signed [FIX_W-1:0] new_vel_z;
        logic [LIFE_W-1:0]       new_life;
        logic                    alive;
        logic                    burst_end;
    } update_t;

endpackage

`default_nettype wire

@@ sv/particle_drag_gravity_step_unit.sv @@
`default_nettype none

// Particle ballistic step with quadratic drag, a sideways force and gravity, in signed
// Q16.16 with saturation. A particle is taken on every clock at which start is high (busy
// never rises), and its update appears on update with done high for one clock, in order,
// one per clock. There is no backpressure: done is not held, so the receiver must take
// every update when it appears. The pipeline is a 32-stage square root for the speed
// followed by 63-stage dividers for the drag and sideways terms, plus eight stages of
// multiply, add and saturate. Registers may be written only while no particle is in
// flight.
module particle_drag_gravity_step_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  pdg_pkg::particle_t                  particle,
    input  logic                                cfg_we,
    input  logic [pdg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pdg_pkg::FIX_W-1:0]           cfg_data,
    output logic                                done,
    output pdg_pkg::update_t                    update
);
    import pdg_pkg::*;

    typedef struct packed {
        particle_t        item;
        logic             alive;
        logic             latx_neg;
        logic             laty_neg;
        logic [QUO_W-1:0] latx_mag;
        logic [QUO_W-1:0] laty_mag;
    } sq_side_t;

    typedef struct packed {
        particle_t         item;
        logic              alive;
        logic              latx_neg;
        logic              laty_neg;
        logic [ROOT_W-1:0] root;
    } dv_side_t;

    localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;
    localparam logic [COEF_W-1:0]  COEF_MAX = '1;

    function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [63:0] x);
        logic signed [FIX_W-1:0] res;
        if (x > SAT_HI)
            res = FIX_W'(SAT_HI);
        else if (x < SAT_LO)
            res = FIX_W'(SAT_LO);
        else
            res = FIX_W'(x);
        return res;
    endfunction

    function automatic logic signed [FIX_W-1:0] sat_mag(input logic neg,
                                                        input logic [QUO_W-1:0] mag);
        logic signed [63:0] val;
        val = $signed(64'(mag));
        if (neg)
            val = -val;
        return sat_fix(val);
    endfunction

    // configuration registers
    logic [TIME_W-1:0]       time_step_reg;
    logic [COEF_W-1:0]       gravity_reg;
    logic [COEF_W-1:0]       drag_c_reg;
    logic [COEF_W-1:0]       drag_l_reg;
    logic [COEF_W-1:0]       drag_q_reg;
    logic signed [FIX_W-1:0] gain_reg;
    logic signed [FIX_W-1:0] floor_reg;
    logic [LIFE_W-1:0]       life_floor_reg;
    logic [TT_W-1:0]         tt_reg;
    logic [2*TIME_W-1:0]     tt_full;

    assign tt_full = (2*TIME_W)'(time_step_reg) * (2*TIME_W)'(time_step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= RST_TIME_STEP;
            gravity_reg    <= RST_GRAVITY;
            drag_c_reg     <= RST_DRAG_C;
            drag_l_reg     <= RST_DRAG_L;
            drag_q_reg     <= RST_DRAG_Q;
            gain_reg       <= RST_LAT_GAIN;
            floor_reg      <= RST_FLOOR;
            life_floor_reg <= RST_LIFE_FLOOR;
            tt_reg         <= RST_TT;
        end
        else
        begin
            tt_reg <= tt_full[TT_W+15:16];
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_TIME_STEP:      time_step_reg  <= cfg_data[TIME_W-1:0];
                    CFG_GRAVITY:        gravity_reg    <= cfg_data[COEF_W-1:0];
                    CFG_DRAG_CONSTANT:  drag_c_reg     <= cfg_data[COEF_W-1:0];
                    CFG_DRAG_LINEAR:    drag_l_reg     <= cfg_data[COEF_W-1:0];
                    CFG_DRAG_QUADRATIC: drag_q_reg     <= cfg_data[COEF_W-1:0];
                    CFG_LATERAL_GAIN:   gain_reg       <= $signed(cfg_data);
                    CFG_FLOOR_HEIGHT:   floor_reg      <= $signed(cfg_data);
                    CFG_LIFE_FLOOR:     life_floor_reg <= cfg_data[LIFE_W-1:0];
                    default:            time_step_reg  <= time_step_reg;
                endcase
            end
        end
    end

    logic signed [63:0] t_ext;
    logic signed [63:0] tt_ext;
    logic signed [63:0] g_ext;
    logic signed [63:0] gain_ext;

    assign t_ext    = $signed(64'(time_step_reg));
    assign tt_ext   = $signed(64'(tt_reg));
    assign g_ext    = $signed(64'(gravity_reg));
    assign gain_ext = 64'(gain_reg);

    assign busy = 1'b0;

    // valid bits
    logic v0_reg, v1_reg, v2_reg, ve_reg, vf_reg, vg_reg, vh_reg, done_reg;
    logic sq_vld_reg [SQRT_LAT];
    logic dv_vld_reg [DIV_LAT];

    // stage 0: capture and life test
    particle_t item0_reg;
    logic      alive0_reg;

    always_ff @(posedge clk)
    begin
        item0_reg  <= particle;
        alive0_reg <= (particle.pos_z > floor_reg) && (particle.life_left > life_floor_reg);
    end

    // stage 1: squares and sideways numerators
    logic signed [63:0] vx0_ext, vy0_ext, vz0_ext;
    logic [SUM_W-1:0]   sqx_reg, sqy_reg, sqz_reg;
    logic signed [63:0] latnx_reg, latny_reg;
    particle_t          item1_reg;
    logic               alive1_reg;

    assign vx0_ext = 64'(item0_reg.vel_x);
    assign vy0_ext = 64'(item0_reg.vel_y);
    assign vz0_ext = 64'(item0_reg.vel_z);

    always_ff @(posedge clk)
    begin
        sqx_reg    <= vx0_ext * vx0_ext;
        sqy_reg    <= vy0_ext * vy0_ext;
        sqz_reg    <= vz0_ext * vz0_ext;
        latnx_reg  <= gain_ext * vy0_ext;
        latny_reg  <= -(gain_ext * vx0_ext);
        item1_reg  <= item0_reg;
        alive1_reg <= alive0_reg;
    end

    // stage 2: sum of squares, sign and magnitude of numerators
    logic [SUM_W-1:0]   sum2_reg;
    sq_side_t           side2_reg;
    logic signed [63:0] latx_abs, laty_abs;

    assign latx_abs = latnx_reg[63] ? -latnx_reg : latnx_reg;
    assign laty_abs = latny_reg[63] ? -latny_reg : latny_reg;

    always_ff @(posedge clk)
    begin
        sum2_reg           <= sqx_reg + sqy_reg + sqz_reg;
        side2_reg.item     <= item1_reg;
        side2_reg.alive    <= alive1_reg;
        side2_reg.latx_neg <= latnx_reg[63];
        side2_reg.laty_neg <= latny_reg[63];
        side2_reg.latx_mag <= latx_abs[QUO_W-1:0];
        side2_reg.laty_mag <= laty_abs[QUO_W-1:0];
    end

    // speed
    logic [ROOT_W-1:0] root;
    sq_side_t          sq_side_reg [SQRT_LAT];
    sq_side_t          sq_out;

    pdg_sqrt u_sqrt (
        .clk      (clk),
        .radicand (sum2_reg),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        sq_side_reg[0] <= side2_reg;
        for (int k = 1; k < SQRT_LAT; k++)
            sq_side_reg[k] <= sq_side_reg[k-1];
    end

    assign sq_out = sq_side_reg[SQRT_LAT-1];

    // divisions by speed
    logic [ROOT_W-1:0] den;
    logic [QUO_W-1:0]  q_drag, q_latx, q_laty;
    dv_side_t          dv_side_reg [DIV_LAT];
    dv_side_t          de;

    assign den = (root == '0) ? ROOT_W'(1) : root;

    pdg_div u_div_drag (
        .clk      (clk),
        .dividend (QUO_W'({drag_c_reg, 16'h0000})),
        .divisor  (den),
        .quotient (q_drag)
    );

    pdg_div u_div_latx (
        .clk      (clk),
        .dividend (sq_out.latx_mag),
        .divisor  (den),
        .quotient (q_latx)
    );

    pdg_div u_div_laty (
        .clk      (clk),
        .dividend (sq_out.laty_mag),
        .divisor  (den),
        .quotient (q_laty)
    );

    always_ff @(posedge clk)
    begin
        dv_side_reg[0].item     <= sq_out.item;
        dv_side_reg[0].alive    <= sq_out.alive;
        dv_side_reg[0].latx_neg <= sq_out.latx_neg;
        dv_side_reg[0].laty_neg <= sq_out.laty_neg;
        dv_side_reg[0].root     <= root;
        for (int k = 1; k < DIV_LAT; k++)
            dv_side_reg[k] <= dv_side_reg[k-1];
    end

    assign de = dv_side_reg[DIV_LAT-1];

    // stage e: drag factor and sideways terms
    logic [63:0]             r2s;
    logic [63:0]             r_sum;
    logic [COEF_W-1:0]       r_e_reg;
    logic signed [FIX_W-1:0] latx_e_reg, laty_e_reg;
    logic                    zero_e_reg;
    particle_t               item_e_reg;
    logic                    alive_e_reg;

    assign r2s   = 64'(drag_q_reg) * 64'(de.root);
    assign r_sum = 64'(r2s[63:16]) + 64'(drag_l_reg) + 64'(q_drag);

    always_ff @(posedge clk)
    begin
        r_e_reg     <= (r_sum > 64'(COEF_MAX)) ? COEF_MAX : r_sum[COEF_W-1:0];
        latx_e_reg  <= sat_mag(de.latx_neg, q_latx);
        laty_e_reg  <= sat_mag(de.laty_neg, q_laty);
        zero_e_reg  <= (de.root == '0);
        item_e_reg  <= de.item;
        alive_e_reg <= de.alive;
    end

    // stage f: drag components and v*t
    logic signed [63:0]      r_ext;
    logic signed [63:0]      vel_e [3];
    logic signed [FIX_W-1:0] d_f_reg [3];
    logic signed [33:0]      vt_f_reg [3];
    logic signed [FIX_W-1:0] latx_f_reg, laty_f_reg;
    logic                    zero_f_reg;
    particle_t               item_f_reg;
    logic                    alive_f_reg;

    assign r_ext    = $signed(64'(r_e_reg));
    assign vel_e[0] = 64'(item_e_reg.vel_x);
    assign vel_e[1] = 64'(item_e_reg.vel_y);
    assign vel_e[2] = 64'(item_e_reg.vel_z);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_f_reg[i]  <= sat_fix((r_ext * vel_e[i]) >>> 16);
            vt_f_reg[i] <= 34'((vel_e[i] * t_ext) >>> 16);
        end
        latx_f_reg  <= latx_e_reg;
        laty_f_reg  <= laty_e_reg;
        zero_f_reg  <= zero_e_reg;
        item_f_reg  <= item_e_reg;
        alive_f_reg <= alive_e_reg;
    end

    // stage g: acceleration
    logic signed [FIX_W-1:0] a_g_reg [3];
    logic signed [33:0]      vt_g_reg [3];
    particle_t               item_g_reg;
    logic                    alive_g_reg;

    always_ff @(posedge clk)
    begin
        if (zero_f_reg)
        begin
            a_g_reg[0] <= '0;
            a_g_reg[1] <= '0;
            a_g_reg[2] <= sat_fix(-g_ext);
        end
        else
        begin
            a_g_reg[0] <= sat_fix(64'(latx_f_reg) - 64'(d_f_reg[0]));
            a_g_reg[1] <= sat_fix(64'(laty_f_reg) - 64'(d_f_reg[1]));
            a_g_reg[2] <= sat_fix(-64'(d_f_reg[2]) - g_ext);
        end
        for (int i = 0; i < 3; i++)
            vt_g_reg[i] <= vt_f_reg[i];
        item_g_reg  <= item_f_reg;
        alive_g_reg <= alive_f_reg;
    end

    // stage h: a*t and a*t*t/2
    logic signed [63:0] a_ext [3];
    logic signed [33:0] at_h_reg [3];
    logic signed [33:0] att_h_reg [3];
    logic signed [33:0] vt_h_reg [3];
    particle_t          item_h_reg;
    logic               alive_h_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            a_ext[i] = 64'(a_g_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            at_h_reg[i]  <= 34'((a_ext[i] * t_ext) >>> 16);
            att_h_reg[i] <= 34'((a_ext[i] * tt_ext) >>> 17);
            vt_h_reg[i]  <= vt_g_reg[i];
        end
        item_h_reg  <= item_g_reg;
        alive_h_reg <= alive_g_reg;
    end

    // stage i: final sums and result register
    logic signed [63:0] pos_h [3];
    logic signed [63:0] vel_h [3];
    update_t            update_reg;

    assign pos_h[0] = 64'(item_h_reg.pos_x);
    assign pos_h[1] = 64'(item_h_reg.pos_y);
    assign pos_h[2] = 64'(item_h_reg.pos_z);
    assign vel_h[0] = 64'(item_h_reg.vel_x);
    assign vel_h[1] = 64'(item_h_reg.vel_y);
    assign vel_h[2] = 64'(item_h_reg.vel_z);

    always_ff @(posedge clk)
    begin
        update_reg.alive     <= alive_h_reg;
        update_reg.burst_end <= item_h_reg.last_in_burst;
        if (alive_h_reg)
        begin
            update_reg.new_pos_x <= sat_fix(pos_h[0] + 64'(vt_h_reg[0]) + 64'(att_h_reg[0]));
            update_reg.new_pos_y <= sat_fix(pos_h[1] + 64'(vt_h_reg[1]) + 64'(att_h_reg[1]));
            update_reg.new_pos_z <= sat_fix(pos_h[2] + 64'(vt_h_reg[2]) + 64'(att_h_reg[2]));
            update_reg.new_vel_x <= sat_fix(vel_h[0] + 64'(at_h_reg[0]));
            update_reg.new_vel_y <= sat_fix(vel_h[1] + 64'(at_h_reg[1]));
            update_reg.new_vel_z <= sat_fix(vel_h[2] + 64'(at_h_reg[2]));
            update_reg.new_life  <= item_h_reg.life_left - LIFE_W'(1);
        end
        else
        begin
            update_reg.new_pos_x <= item_h_reg.pos_x;
            update_reg.new_pos_y <= item_h_reg.pos_y;
            update_reg.new_pos_z <= item_h_reg.pos_z;
            update_reg.new_vel_x <= item_h_reg.vel_x;
            update_reg.new_vel_y <= item_h_reg.vel_y;
            update_reg.new_vel_z <= item_h_reg.vel_z;
            update_reg.new_life  <= item_h_reg.life_left;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ve_reg   <= 1'b0;
            vf_reg   <= 1'b0;
            vg_reg   <= 1'b0;
            vh_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int k = 0; k < SQRT_LAT; k++)
                sq_vld_reg[k] <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
                dv_vld_reg[k] <= 1'b0;
        end
        else
        begin
            v0_reg        <= start && !busy;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            sq_vld_reg[0] <= v2_reg;
            for (int k = 1; k < SQRT_LAT; k++)
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            dv_vld_reg[0] <= sq_vld_reg[SQRT_LAT-1];
            for (int k = 1; k < DIV_LAT; k++)
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            ve_reg   <= dv_vld_reg[DIV_LAT-1];
            vf_reg   <= ve_reg;
            vg_reg   <= vf_reg;
            vh_reg   <= vg_reg;
            done_reg <= vh_reg;
        end
    end

    assign done   = done_reg;
    assign update = update_reg;

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without a matching item");

    a_dead_passes: assert property (@(posedge clk) disable iff (!rst_n)
        done && !update.alive |->
            update.new_life == $past(particle.life_left, PIPE_LAT) &&
            update.new_pos_z == $past(particle.pos_z, PIPE_LAT))
        else $error("dead particle not passed through");

    a_life_drops: assert property (@(posedge clk) disable iff (!rst_n)
        done && update.alive |->
            update.new_life == $past(particle.life_left, PIPE_LAT) - LIFE_W'(1))
        else $error("live particle life not decremented");

    a_burst_copy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> update.burst_end == $past(particle.last_in_burst, PIPE_LAT))
        else $error("burst mark lost");

endmodule

`default_nettype wire

@@ sv/pdg_sqrt.sv @@
`default_nettype none

module pdg_sqrt (
    input  logic                         clk,
    input  logic [pdg_pkg::SUM_W-1:0]    radicand,
    output logic [pdg_pkg::ROOT_W-1:0]   root
);
    import pdg_pkg::*;

    logic [SUM_W-1:0]  rad_reg  [SQRT_LAT];
    logic [ROOT_W:0]   rem_reg  [SQRT_LAT];
    logic [ROOT_W-1:0] q_reg    [SQRT_LAT];
    logic [SUM_W-1:0]  rad_next [SQRT_LAT];
    logic [ROOT_W:0]   rem_next [SQRT_LAT];
    logic [ROOT_W-1:0] q_next   [SQRT_LAT];
    logic [SUM_W-1:0]  rad_in;
    logic [ROOT_W:0]   rem_in;
    logic [ROOT_W-1:0] q_in;
    logic [ROOT_W+2:0] shifted;
    logic [ROOT_W+2:0] trial;

    // one result bit per stage, two radicand bits per stage
    always_comb
    begin
        rad_in  = '0;
        rem_in  = '0;
        q_in    = '0;
        shifted = '0;
        trial   = '0;
        for (int k = 0; k < SQRT_LAT; k++)
        begin
            if (k == 0)
            begin
                rad_in = radicand;
                rem_in = '0;
                q_in   = '0;
            end
            else
            begin
                rad_in = rad_reg[k-1];
                rem_in = rem_reg[k-1];
                q_in   = q_reg[k-1];
            end
            shifted     = {rem_in, rad_in[SUM_W-1 -: 2]};
            trial       = {1'b0, q_in, 2'b01};
            rad_next[k] = {rad_in[SUM_W-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next[k] = (ROOT_W+1)'(shifted - trial);
                q_next[k]   = {q_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = (ROOT_W+1)'(shifted);
                q_next[k]   = {q_in[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQRT_LAT; k++)
        begin
            rad_reg[k] <= rad_next[k];
            rem_reg[k] <= rem_next[k];
            q_reg[k]   <= q_next[k];
        end
    end

    assign root = q_reg[SQRT_LAT-1];

endmodule

`default_nettype wire

@@ sv/pdg_div.sv @@
`default_nettype none

module pdg_div (
    input  logic                         clk,
    input  logic [pdg_pkg::QUO_W-1:0]    dividend,
    input  logic [pdg_pkg::ROOT_W-1:0]   divisor,
    output logic [pdg_pkg::QUO_W-1:0]    quotient
);
    import pdg_pkg::*;

    logic [QUO_W-1:0]  acc_reg  [DIV_LAT];
    logic [ROOT_W-1:0] rem_reg  [DIV_LAT];
    logic [ROOT_W-1:0] den_reg  [DIV_LAT];
    logic [QUO_W-1:0]  acc_next [DIV_LAT];
    logic [ROOT_W-1:0] rem_next [DIV_LAT];
    logic [ROOT_W-1:0] den_next [DIV_LAT];
    logic [QUO_W-1:0]  acc_in;
    logic [ROOT_W-1:0] rem_in;
    logic [ROOT_W-1:0] den_in;
    logic [ROOT_W:0]   part;

    // restoring division, one quotient bit per stage
    always_comb
    begin
        acc_in = '0;
        rem_in = '0;
        den_in = '0;
        part   = '0;
        for (int k = 0; k < DIV_LAT; k++)
        begin
            if (k == 0)
            begin
                acc_in = dividend;
                rem_in = '0;
                den_in = divisor;
            end
            else
            begin
                acc_in = acc_reg[k-1];
                rem_in = rem_reg[k-1];
                den_in = den_reg[k-1];
            end
            part        = {rem_in, acc_in[QUO_W-1]};
            den_next[k] = den_in;
            if (part >= {1'b0, den_in})
            begin
                rem_next[k] = ROOT_W'(part - {1'b0, den_in});
                acc_next[k] = {acc_in[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = ROOT_W'(part);
                acc_next[k] = {acc_in[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_LAT; k++)
        begin
            acc_reg[k] <= acc_next[k];
            rem_reg[k] <= rem_next[k];
            den_reg[k] <= den_next[k];
        end
    end

    assign quotient = acc_reg[DIV_LAT-1];

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import pdg_pkg::*;

    class particle_scoreboard;
        logic [TIME_W-1:0]       time_step;
        logic [COEF_W-1:0]       gravity;
        logic [COEF_W-1:0]       drag_c;
        logic [COEF_W-1:0]       drag_l;
        logic [COEF_W-1:0]       drag_q;
        logic signed [FIX_W-1:0] lat_gain;
        logic signed [FIX_W-1:0] floor_h;
        logic [LIFE_W-1:0]       life_fl;
        update_t                 pending_updates[$];
        int                      errors;

        function new();
            time_step = RST_TIME_STEP;
            gravity   = RST_GRAVITY;
            drag_c    = RST_DRAG_C;
            drag_l    = RST_DRAG_L;
            drag_q    = RST_DRAG_Q;
            lat_gain  = RST_LAT_GAIN;
            floor_h   = RST_FLOOR;
            life_fl   = RST_LIFE_FLOOR;
            errors    = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [FIX_W-1:0] d);
            case (idx)
                CFG_TIME_STEP:      time_step = d[TIME_W-1:0];
                CFG_GRAVITY:        gravity   = d[COEF_W-1:0];
                CFG_DRAG_CONSTANT:  drag_c    = d[COEF_W-1:0];
                CFG_DRAG_LINEAR:    drag_l    = d[COEF_W-1:0];
                CFG_DRAG_QUADRATIC: drag_q    = d[COEF_W-1:0];
                CFG_LATERAL_GAIN:   lat_gain  = d;
                CFG_FLOOR_HEIGHT:   floor_h   = d;
                CFG_LIFE_FLOOR:     life_fl   = d[LIFE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [FIX_W-1:0] sat(longint x);
            if (x > 64'sd2147483647)
                return 32'sh7fffffff;
            if (x < -64'sd2147483648)
                return 32'sh80000000;
            return x[FIX_W-1:0];
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned root;
            longint unsigned b;
            root = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= root + b)
                begin
                    n = n - (root + b);
                    root = (root >> 1) + b;
                end
                else
                    root = root >> 1;
                b = b >> 2;
            end
            return root;
        endfunction

        function update_t advance(particle_t p);
            update_t         u;
            longint          pv[3];
            longint          vv[3];
            longint          av[3];
            longint          dd[3];
            longint unsigned sum;
            longint unsigned spd;
            longint unsigned r;
            longint          t;
            longint          tt;
            longint          rs;
            longint          latx;
            longint          laty;
            logic signed [FIX_W-1:0] np[3];
            logic signed [FIX_W-1:0] nv[3];
            pv[0] = longint'(p.pos_x);
            pv[1] = longint'(p.pos_y);
            pv[2] = longint'(p.pos_z);
            vv[0] = longint'(p.vel_x);
            vv[1] = longint'(p.vel_y);
            vv[2] = longint'(p.vel_z);
            for (int i = 0; i < 3; i++)
            begin
                np[i] = pv[i][FIX_W-1:0];
                nv[i] = vv[i][FIX_W-1:0];
            end
            u.new_life  = p.life_left;
            u.alive     = (p.pos_z > floor_h) && (p.life_left > life_fl);
            u.burst_end = p.last_in_burst;
            if (u.alive)
            begin
                u.new_life = p.life_left - LIFE_W'(1);
                t  = longint'(time_step);
                tt = (t * t) >>> 16;
                sum = 0;
                for (int i = 0; i < 3; i++)
                    sum = sum + longint'(vv[i] * vv[i]);
                spd = root_floor(sum);
                if (spd == 0)
                begin
                    av[0] = 0;
                    av[1] = 0;
                    av[2] = longint'(sat(-longint'(gravity)));
                end
                else
                begin
                    r = ((longint'(drag_q) * spd) >> 16) + longint'(drag_l)
                        + ((longint'(drag_c) << 16) / spd);
                    if (r > 64'd2147483647)
                        r = 64'd2147483647;
                    rs = longint'(r);
                    for (int i = 0; i < 3; i++)
                        dd[i] = longint'(sat((rs * vv[i]) >>> 16));
                    latx = longint'(sat((longint'(lat_gain) * vv[1]) / longint'(spd)));
                    laty = longint'(sat((longint'(lat_gain) * (-vv[0])) / longint'(spd)));
                    av[0] = longint'(sat(latx - dd[0]));
                    av[1] = longint'(sat(laty - dd[1]));
                    av[2] = longint'(sat(-dd[2] - longint'(gravity)));
                end
                for (int i = 0; i < 3; i++)
                begin
                    np[i] = sat(pv[i] + ((vv[i] * t) >>> 16) + ((av[i] * tt) >>> 17));
                    nv[i] = sat(vv[i] + ((av[i] * t) >>> 16));
                end
            end
            u.new_pos_x = np[0];
            u.new_pos_y = np[1];
            u.new_pos_z = np[2];
            u.new_vel_x = nv[0];
            u.new_vel_y = nv[1];
            u.new_vel_z = nv[2];
            return u;
        endfunction

        function void note_particle(particle_t p);
            pending_updates.push_back(advance(p));
        endfunction

        function void cmp(string name, logic [FIX_W-1:0] e, logic [FIX_W-1:0] a);
            if (e !== a)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
            end
        endfunction

        function void check_update(update_t a);
            update_t e;
            if (pending_updates.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected update, expected none, actual %h", $time, a);
                return;
            end
            e = pending_updates.pop_front();
            cmp("new_pos_x", e.new_pos_x, a.new_pos_x);
            cmp("new_pos_y", e.new_pos_y, a.new_pos_y);
            cmp("new_pos_z", e.new_pos_z, a.new_pos_z);
            cmp("new_vel_x", e.new_vel_x, a.new_vel_x);
            cmp("new_vel_y", e.new_vel_y, a.new_vel_y);
            cmp("new_vel_z", e.new_vel_z, a.new_vel_z);
            cmp("new_life", 32'(e.new_life), 32'(a.new_life));
            cmp("alive", 32'(e.alive), 32'(a.alive));
            cmp("burst_end", 32'(e.burst_end), 32'(a.burst_end));
        endfunction
    endclass

    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    particle_t particle;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIX_W-1:0] cfg_data;
    logic done;
    update_t update;

    particle_scoreboard sb;
    int idle_cycles = 0;
    bit allow_gaps;

    particle_drag_gravity_step_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .particle(particle),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .done(done),
        .update(update)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_idx_t'(cfg_index), cfg_data);
            if (start && !busy)
                sb.note_particle(particle);
            if (done)
                sb.check_update(update);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    task automatic set_reg(cfg_idx_t idx, logic [FIX_W-1:0] d);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_updates.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 5) @(posedge clk);
    endtask

    task automatic send(particle_t p);
        bit b;
        start    <= 1'b1;
        particle <= p;
        do
        begin
            @(negedge clk);
            b = busy;
            @(posedge clk);
        end
        while (b);
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    function automatic logic [FIX_W-1:0] rand_vel();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            3, 4: return $urandom;
            5: return 32'($urandom_range(0, 100)) - 32'd50;
            default: return 32'($urandom_range(0, 32'h00400000)) - 32'h00200000;
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        longint z;
        p.pos_x = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 32'h0fffffff)) - 32'h08000000;
        p.pos_y = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 32'h0fffffff)) - 32'h08000000;
        z = longint'(sb.floor_h) + longint'($urandom_range(1, 32'h01000000));
        if ($urandom_range(0, 5) == 0 || z > 64'sd2147483647)
            p.pos_z = $urandom;
        else
            p.pos_z = z[FIX_W-1:0];
        p.vel_x = rand_vel();
        p.vel_y = rand_vel();
        p.vel_z = rand_vel();
        if ($urandom_range(0, 5) == 0 || sb.life_fl == 8'hff)
            p.life_left = $urandom;
        else
            p.life_left = 8'($urandom_range(sb.life_fl + 1, 255));
        p.last_in_burst = $urandom;
        return p;
    endfunction

    function automatic particle_t mk(logic [FIX_W-1:0] z, logic [FIX_W-1:0] vx,
                                     logic [FIX_W-1:0] vy, logic [FIX_W-1:0] vz,
                                     logic [LIFE_W-1:0] life, logic last);
        particle_t p;
        p.pos_x = 32'h00010000;
        p.pos_y = 32'hfffe0000;
        p.pos_z = z;
        p.vel_x = vx;
        p.vel_y = vy;
        p.vel_z = vz;
        p.life_left = life;
        p.last_in_burst = last;
        return p;
    endfunction

    task automatic random_phase(int n);
        repeat (n) send(rand_particle());
        drain();
    endtask

    initial
    begin
        particle_t p;
        sb = new();
        allow_gaps = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        particle = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at reset settings
        send(mk(32'h00140000, 32'h0, 32'h0, 32'h0, 8'd50, 1'b0));
        send(mk(32'h000a0000, 32'h00010000, 32'h0, 32'h0, 8'd50, 1'b1));
        send(mk(32'h000a0001, 32'h00010000, 32'h0, 32'h0, 8'd11, 1'b0));
        send(mk(32'h00140000, 32'h00010000, 32'h0, 32'h0, 8'd10, 1'b1));
        send(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 8'd255, 1'b1));
        send(mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 8'd255, 1'b0));
        send(mk(32'h80000000, 32'h00050000, 32'h0, 32'h0, 8'd0, 1'b1));
        send(mk(32'h00140000, 32'h0, 32'h0, 32'h00000001, 8'd200, 1'b0));
        send(mk(32'h00140000, 32'hffffffff, 32'h00000001, 32'h0, 8'd200, 1'b1));
        p = mk(32'h40000000, 32'h00100000, 32'hfff00000, 32'h00200000, 8'd100, 1'b0);
        p.pos_x = 32'h7fffffff;
        p.pos_y = 32'h80000000;
        send(p);
        p.pos_x = 32'h80000000;
        p.pos_y = 32'h7fffffff;
        send(p);
        drain();
        random_phase(60);

        // extremes: large step, heavy drag, strong positive side gain
        set_reg(CFG_TIME_STEP, 32'h1ffff);
        set_reg(CFG_GRAVITY, 32'h7fffffff);
        set_reg(CFG_DRAG_CONSTANT, 32'h7fffffff);
        set_reg(CFG_DRAG_LINEAR, 32'h7fffffff);
        set_reg(CFG_DRAG_QUADRATIC, 32'h7fffffff);
        set_reg(CFG_LATERAL_GAIN, 32'h7fffffff);
        set_reg(CFG_FLOOR_HEIGHT, 32'h80000000);
        set_reg(CFG_LIFE_FLOOR, 32'h0);
        send(mk(32'h80000001, 32'h0, 32'h0, 32'h0, 8'd1, 1'b1));
        send(mk(32'h80000000, 32'h00010000, 32'h0, 32'h0, 8'd1, 1'b0));
        send(mk(32'h00000000, 32'h00000001, 32'h0, 32'h0, 8'd0, 1'b1));
        drain();
        random_phase(60);

        // zero step, no gravity or drag, most negative gain, top floor
        set_reg(CFG_TIME_STEP, 32'h0);
        set_reg(CFG_GRAVITY, 32'h0);
        set_reg(CFG_DRAG_CONSTANT, 32'h0);
        set_reg(CFG_DRAG_LINEAR, 32'h0);
        set_reg(CFG_DRAG_QUADRATIC, 32'h0);
        set_reg(CFG_LATERAL_GAIN, 32'h80000000);
        set_reg(CFG_FLOOR_HEIGHT, 32'h7fffffff);
        set_reg(CFG_LIFE_FLOOR, 32'hff);
        send(mk(32'h7fffffff, 32'h00010000, 32'h0, 32'h0, 8'd255, 1'b1));
        random_phase(20);

        set_reg(CFG_FLOOR_HEIGHT, 32'hfff00000);
        set_reg(CFG_LIFE_FLOOR, 32'h0);
        set_reg(CFG_TIME_STEP, 32'h10000);
        set_reg(CFG_LATERAL_GAIN, 32'h80000000);
        random_phase(60);

        // random moderate settings, one stretch without gaps at the end
        for (int k = 0; k < 3; k++)
        begin
            set_reg(CFG_TIME_STEP, $urandom_range(0, 32'h1ffff));
            set_reg(CFG_GRAVITY, $urandom_range(0, 32'h00ffffff));
            set_reg(CFG_DRAG_CONSTANT, $urandom_range(0, 32'h0000ffff));
            set_reg(CFG_DRAG_LINEAR, $urandom_range(0, 32'h0000ffff));
            set_reg(CFG_DRAG_QUADRATIC, $urandom_range(0, 32'h00000fff));
            set_reg(CFG_LATERAL_GAIN, $urandom);
            set_reg(CFG_FLOOR_HEIGHT, $urandom);
            set_reg(CFG_LIFE_FLOOR, $urandom_range(0, 200));
            if (k == 2)
                allow_gaps = 1'b0;
            random_phase(70);
        end

        drain();
        if (sb.errors == 0 && sb.pending_updates.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
